@@ rtl/core/dqme_pkg.sv @@
package dqme_pkg;

  // Label length counter width; a label never holds more than 63 characters.
  localparam int LEN_W = 6;
  localparam int MAX_LABEL_DEF = 63;

  // Configuration port geometry: seven 32-bit registers at word addresses.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Queue depths between the parts.
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 3;

  // Label separator character.
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_RESPONSE_FLAG      = 3'd0;
  localparam logic [2:0] REG_OPERATION_CODE     = 3'd1;
  localparam logic [2:0] REG_AUTHORITATIVE_FLAG = 3'd2;
  localparam logic [2:0] REG_TRUNCATED_FLAG     = 3'd3;
  localparam logic [2:0] REG_RECURSION_DESIRED  = 3'd4;
  localparam logic [2:0] REG_RESULT_CODE        = 3'd5;
  localparam logic [2:0] REG_QUERY_CLASS        = 3'd6;

  typedef enum logic [1:0] {
    ACT_BEGIN  = 2'd0,
    ACT_CHAR   = 2'd1,
    ACT_END    = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_LABEL  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] query_id;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [7:0]  name_char;
  } in_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic [15:0]      query_id;
    logic [15:0]      question_count;
    logic [15:0]      answer_count;
    logic [15:0]      authority_count;
    logic [15:0]      additional_count;
    logic [15:0]      qtype;
  } cmd_t;

  typedef struct packed {
    logic        response_flag;
    logic [3:0]  operation_code;
    logic        authoritative_flag;
    logic        truncated_flag;
    logic        recursion_desired;
    logic [3:0]  result_code;
    logic [15:0] query_class;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       message_end;
    logic       label_overflow;
  } out_item_t;

  typedef struct packed {
    logic cmd_pop;
    logic flush_done;
  } bk_status_t;

endpackage

@@ rtl/core/dqme_ram.sv @@
module dqme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dqme_fifo.sv @@
module dqme_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic [CW-1:0]    count,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ rtl/core/dqme_front.sv @@
module dqme_front #(
  parameter int MAX_LABEL = dqme_pkg::MAX_LABEL_DEF,
  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  dqme_pkg::in_item_t   item,
  input  logic                 cq_full,
  output logic                 cmd_push,
  output dqme_pkg::cmd_t       cmd_data,
  input  dqme_pkg::bk_status_t status,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [7:0]           ram_wdata
);

  import dqme_pkg::*;

  logic [LEN_W-1:0] label_length;
  logic [LEN_W-1:0] label_length_next;
  logic             overflow_seen;
  logic             overflow_seen_next;
  logic [15:0]      held_query_type;
  logic [15:0]      held_query_type_next;
  logic             flush_busy;
  logic             flush_busy_next;
  logic             accept;

  // Hold off new items while the command queue is full or the back end still reads a stored label.
  assign full      = cq_full || flush_busy;
  assign accept    = push && !full;
  assign ram_waddr = label_length[AW-1:0];
  assign ram_wdata = item.name_char;

  // Classify the accepted item, store its character or issue a command to the back end.
  always_comb begin
    label_length_next       = label_length;
    overflow_seen_next      = overflow_seen;
    held_query_type_next    = held_query_type;
    flush_busy_next         = flush_busy;
    cmd_push                = 1'b0;
    ram_we                  = 1'b0;
    cmd_data.kind           = CMD_HEADER;
    cmd_data.len            = label_length;
    cmd_data.ovf            = overflow_seen;
    cmd_data.query_id       = item.query_id;
    cmd_data.question_count = item.question_count;
    cmd_data.answer_count   = item.answer_count;
    cmd_data.authority_count  = item.authority_count;
    cmd_data.additional_count = item.additional_count;
    cmd_data.qtype          = held_query_type;

    if (status.flush_done) begin
      flush_busy_next = 1'b0;
    end

    if (accept) begin
      unique case (item.action)
        ACT_BEGIN: begin
          cmd_push             = 1'b1;
          cmd_data.ovf         = 1'b0;
          held_query_type_next = item.query_type;
          label_length_next    = '0;
          overflow_seen_next   = 1'b0;
        end
        ACT_CHAR: begin
          if (item.name_char == DOT_CHAR) begin
            cmd_push          = 1'b1;
            cmd_data.kind     = CMD_LABEL;
            label_length_next = '0;
            if (label_length != '0) begin
              flush_busy_next = 1'b1;
            end
          end else if (label_length < LEN_W'(MAX_LABEL)) begin
            ram_we            = 1'b1;
            label_length_next = label_length + 1'b1;
          end else begin
            overflow_seen_next = 1'b1;
          end
        end
        ACT_END: begin
          if (label_length != '0) begin
            cmd_push          = 1'b1;
            cmd_data.kind     = CMD_LABEL;
            label_length_next = '0;
            flush_busy_next   = 1'b1;
          end
        end
        ACT_FINISH: begin
          cmd_push          = 1'b1;
          cmd_data.kind     = CMD_FINISH;
          label_length_next = '0;
        end
      endcase
    end
  end

  // Front end state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      label_length    <= '0;
      overflow_seen   <= 1'b0;
      held_query_type <= '0;
      flush_busy      <= 1'b0;
    end else begin
      label_length    <= label_length_next;
      overflow_seen   <= overflow_seen_next;
      held_query_type <= held_query_type_next;
      flush_busy      <= flush_busy_next;
    end
  end

endmodule

@@ rtl/core/dqme_back.sv @@
module dqme_back #(
  parameter int MAX_LABEL = dqme_pkg::MAX_LABEL_DEF,
  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dqme_pkg::cfg_t       cfg,
  input  logic                 cmd_valid,
  input  dqme_pkg::cmd_t       cmd,
  output dqme_pkg::bk_status_t status,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr,
  input  logic [7:0]           ram_rdata,
  input  logic                 pop,
  output logic                 empty,
  output dqme_pkg::out_item_t  item
);

  import dqme_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam logic [LEN_W-1:0] HDR_LAST = LEN_W'(11);
  localparam logic [LEN_W-1:0] FIN_LAST = LEN_W'(4);

  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] last_pos;
  logic [LEN_W-1:0] ram_idx;
  logic             is_last;
  logic             issue;
  logic [OCW-1:0]   ocount;
  logic [OCW:0]     in_flight;
  logic [7:0]       sel_byte;
  logic             sel_ram;
  logic             sel_end;
  logic             s1_valid;
  logic             s1_ram;
  out_item_t        s1_item;
  out_item_t        opush_data;
  logic [$bits(out_item_t)-1:0] ordata;

  // Last byte position of the command at the head of the queue.
  always_comb begin
    unique case (cmd.kind)
      CMD_HEADER: last_pos = HDR_LAST;
      CMD_LABEL:  last_pos = cmd.len;
      CMD_FINISH: last_pos = FIN_LAST;
      default:    last_pos = '0;
    endcase
  end

  // Issue one byte a cycle while a command waits and the output queue has room for it.
  assign in_flight = {1'b0, ocount} + (OCW + 1)'(s1_valid);
  assign issue     = cmd_valid && (in_flight < (OCW + 1)'(OUT_DEPTH));
  assign is_last   = (pos == last_pos);
  assign ram_idx   = pos - 1'b1;
  assign ram_raddr = ram_idx[AW-1:0];
  assign ram_re    = issue && sel_ram;

  assign status.cmd_pop    = issue && is_last;
  assign status.flush_done = issue && is_last && (cmd.kind == CMD_LABEL) && (cmd.len != '0);

  // Select the byte for the current position of the command.
  always_comb begin
    sel_byte = '0;
    sel_ram  = 1'b0;
    sel_end  = 1'b0;
    unique case (cmd.kind)
      CMD_HEADER: begin
        unique case (pos)
          LEN_W'(0):  sel_byte = cmd.query_id[15:8];
          LEN_W'(1):  sel_byte = cmd.query_id[7:0];
          LEN_W'(2):  sel_byte = {cfg.response_flag, cfg.operation_code,
                                  cfg.authoritative_flag, cfg.truncated_flag,
                                  cfg.recursion_desired};
          LEN_W'(3):  sel_byte = {4'b0000, cfg.result_code};
          LEN_W'(4):  sel_byte = cmd.question_count[15:8];
          LEN_W'(5):  sel_byte = cmd.question_count[7:0];
          LEN_W'(6):  sel_byte = cmd.answer_count[15:8];
          LEN_W'(7):  sel_byte = cmd.answer_count[7:0];
          LEN_W'(8):  sel_byte = cmd.authority_count[15:8];
          LEN_W'(9):  sel_byte = cmd.authority_count[7:0];
          LEN_W'(10): sel_byte = cmd.additional_count[15:8];
          LEN_W'(11): sel_byte = cmd.additional_count[7:0];
          default:    sel_byte = '0;
        endcase
      end
      CMD_LABEL: begin
        // The length byte leads; the characters come from the label store.
        if (pos == '0) begin
          sel_byte = 8'(cmd.len);
        end else begin
          sel_ram = 1'b1;
        end
      end
      CMD_FINISH: begin
        unique case (pos)
          LEN_W'(1): sel_byte = cmd.qtype[15:8];
          LEN_W'(2): sel_byte = cmd.qtype[7:0];
          LEN_W'(3): sel_byte = cfg.query_class[15:8];
          LEN_W'(4): sel_byte = cfg.query_class[7:0];
          default:   sel_byte = '0;
        endcase
        sel_end = (pos == FIN_LAST);
      end
      default: sel_byte = '0;
    endcase
  end

  // Position counter and the stage that waits for the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        pos <= is_last ? '0 : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ram                 <= sel_ram;
      s1_item.out_byte       <= sel_byte;
      s1_item.last_of_run    <= is_last;
      s1_item.message_end    <= sel_end;
      s1_item.label_overflow <= cmd.ovf;
    end
  end

  // Merge the store data into the byte on its way to the output queue.
  always_comb begin
    opush_data = s1_item;
    if (s1_ram) begin
      opush_data.out_byte = ram_rdata;
    end
  end

  dqme_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s1_valid),
    .wdata (opush_data),
    .pop   (pop),
    .rdata (ordata),
    .count (ocount),
    .full  (),
    .empty (empty)
  );

  assign item = out_item_t'(ordata);

endmodule

@@ rtl/core/dns_query_message_encoder.sv @@
// DNS query message encoder.
// Input channel: an item is transferred when push is high and full is low.
// A begin item yields the 12 header bytes, a dot (or an end-of-name after
// stored characters) yields a label (length byte, then its characters), and
// finish yields the zero terminator, query type and query class. Other name
// characters are stored, or dropped past the limit, and yield nothing.
// Result channel: the oldest byte is on out_byte while empty is low and is
// transferred when pop is high; last_of_run marks the final byte of an item
// and message_end the final byte of the message.
// The first byte of an item passes the command queue, the read stage and
// the output queue before it shows. Throughput: the back end emits one byte
// per cycle while the output queue has room. The label store has a single
// write and a single read port, so input stalls while a label is read out.
// Reset clears all queues and control state and loads the registers with
// their defaults. When pop stays low the output queue fills, then the
// command queue, and full rises; nothing is lost.
// Configuration is to be written over the register port only while idle; the block does not enforce it.
module dns_query_message_encoder #(
  parameter int MAX_LABEL = dqme_pkg::MAX_LABEL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    action,
  input  logic [15:0]                   query_id,
  input  logic [15:0]                   question_count,
  input  logic [15:0]                   answer_count,
  input  logic [15:0]                   authority_count,
  input  logic [15:0]                   additional_count,
  input  logic [15:0]                   query_type,
  input  logic [7:0]                    name_char,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          last_of_run,
  output logic                          message_end,
  output logic                          label_overflow,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dqme_pkg::ADDR_W-1:0]   paddr,
  input  logic [dqme_pkg::DATA_W-1:0]   pwdata,
  output logic [dqme_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  import dqme_pkg::*;

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  cfg_t       cfg;
  in_item_t   in_item;
  out_item_t  out_item;
  cmd_t       cq_wdata;
  logic [$bits(cmd_t)-1:0] cq_rdata;
  logic       cq_push;
  logic       cq_full;
  logic       cq_empty;
  bk_status_t bk_status;
  logic       ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic       ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0] ram_rdata;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  // Register port: always ready, written on the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.response_flag      <= 1'b0;
      cfg.operation_code     <= '0;
      cfg.authoritative_flag <= 1'b0;
      cfg.truncated_flag     <= 1'b0;
      cfg.recursion_desired  <= 1'b0;
      cfg.result_code        <= '0;
      cfg.query_class        <= 16'h0001;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RESPONSE_FLAG:      cfg.response_flag      <= pwdata[0];
        REG_OPERATION_CODE:     cfg.operation_code     <= pwdata[3:0];
        REG_AUTHORITATIVE_FLAG: cfg.authoritative_flag <= pwdata[0];
        REG_TRUNCATED_FLAG:     cfg.truncated_flag     <= pwdata[0];
        REG_RECURSION_DESIRED:  cfg.recursion_desired  <= pwdata[0];
        REG_RESULT_CODE:        cfg.result_code        <= pwdata[3:0];
        REG_QUERY_CLASS:        cfg.query_class        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_RESPONSE_FLAG:      prdata = DATA_W'(cfg.response_flag);
      REG_OPERATION_CODE:     prdata = DATA_W'(cfg.operation_code);
      REG_AUTHORITATIVE_FLAG: prdata = DATA_W'(cfg.authoritative_flag);
      REG_TRUNCATED_FLAG:     prdata = DATA_W'(cfg.truncated_flag);
      REG_RECURSION_DESIRED:  prdata = DATA_W'(cfg.recursion_desired);
      REG_RESULT_CODE:        prdata = DATA_W'(cfg.result_code);
      REG_QUERY_CLASS:        prdata = DATA_W'(cfg.query_class);
      default:                prdata = '0;
    endcase
  end

  // Gather the input fields into one item.
  always_comb begin
    in_item.action           = action_t'(action);
    in_item.query_id         = query_id;
    in_item.question_count   = question_count;
    in_item.answer_count     = answer_count;
    in_item.authority_count  = authority_count;
    in_item.additional_count = additional_count;
    in_item.query_type       = query_type;
    in_item.name_char        = name_char;
  end

  dqme_front #(
    .MAX_LABEL (MAX_LABEL)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (in_item),
    .cq_full   (cq_full),
    .cmd_push  (cq_push),
    .cmd_data  (cq_wdata),
    .status    (bk_status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  dqme_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wdata (cq_wdata),
    .pop   (bk_status.cmd_pop),
    .rdata (cq_rdata),
    .count (),
    .full  (cq_full),
    .empty (cq_empty)
  );

  dqme_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dqme_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cq_empty),
    .cmd       (cmd_t'(cq_rdata)),
    .status    (bk_status),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .empty     (empty),
    .item      (out_item)
  );

  assign out_byte       = out_item.out_byte;
  assign last_of_run    = out_item.last_of_run;
  assign message_end    = out_item.message_end;
  assign label_overflow = out_item.label_overflow;

`ifndef SYNTHESIS
  // The last byte of a message always closes its item.
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && message_end) |-> last_of_run)
    else $error("message_end without last_of_run");

  // The front end never issues into a full command queue.
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cq_push |-> !cq_full)
    else $error("command queue overflow");

  // A label readout only finishes on a command that is present.
  a_flush_has_cmd: assert property (@(posedge clk) disable iff (rst)
    bk_status.flush_done |-> (!cq_empty && bk_status.cmd_pop))
    else $error("label readout finished without a command");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("result waiting after reset");
`endif

endmodule

@@ tb/dns_query_message_encoder_checker.sv @@
`timescale 1ns / 100ps
module dns_query_message_encoder_checker
  import dqme_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic [1:0]                  action,
  input  logic [15:0]                 query_id,
  input  logic [15:0]                 question_count,
  input  logic [15:0]                 answer_count,
  input  logic [15:0]                 authority_count,
  input  logic [15:0]                 additional_count,
  input  logic [15:0]                 query_type,
  input  logic [7:0]                  name_char,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [7:0]                  out_byte,
  input  logic                        last_of_run,
  input  logic                        message_end,
  input  logic                        label_overflow,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [DATA_W-1:0]           pwdata,
  output int                          mismatches,
  output int                          bytes_waiting
);

  // Shadow of the register file and of the encoder state.
  cfg_t             shadow_cfg;
  logic [7:0]       label_chars [MAX_LABEL_DEF];
  logic [LEN_W-1:0] label_len;
  logic [15:0]      held_qtype;
  logic             overflow_seen;

  // Bytes of the current item, then all bytes still owed by the block.
  out_item_t        item_bytes[$];
  out_item_t        expected_bytes[$];
  int               errors;

  task automatic emit_byte(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    item_bytes = {item_bytes, r};
  endtask

  task automatic emit_word(input logic [15:0] w);
    emit_byte(w[15:8]);
    emit_byte(w[7:0]);
  endtask

  // A label goes out as its length byte followed by its characters.
  task automatic flush_label();
    emit_byte({2'b00, label_len});
    for (int i = 0; i < label_len; i++) begin
      emit_byte(label_chars[i]);
    end
    label_len = '0;
  endtask

  // Works out the bytes that one accepted input item produces.
  task automatic encode_item(input action_t act, input logic [7:0] ch);
    item_bytes = {};
    case (act)
      ACT_BEGIN: begin
        held_qtype = query_type;
        label_len = '0;
        overflow_seen = 1'b0;
        emit_word(query_id);
        emit_byte({shadow_cfg.response_flag, shadow_cfg.operation_code,
                   shadow_cfg.authoritative_flag, shadow_cfg.truncated_flag,
                   shadow_cfg.recursion_desired});
        emit_byte({4'b0000, shadow_cfg.result_code});
        emit_word(question_count);
        emit_word(answer_count);
        emit_word(authority_count);
        emit_word(additional_count);
      end
      ACT_CHAR: begin
        if (ch == DOT_CHAR) begin
          flush_label();
        end else if (label_len < MAX_LABEL_DEF) begin
          label_chars[label_len] = ch;
          label_len = label_len + 1'b1;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      ACT_END: begin
        if (label_len != 0) flush_label();
      end
      default: begin
        // Finish drops any pending label characters.
        label_len = '0;
        emit_byte(8'h00);
        emit_word(held_qtype);
        emit_word(shadow_cfg.query_class);
        item_bytes[item_bytes.size()-1].message_end = 1'b1;
      end
    endcase
    foreach (item_bytes[k]) item_bytes[k].label_overflow = overflow_seen;
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last_of_run = 1'b1;
    expected_bytes = {expected_bytes, item_bytes};
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      shadow_cfg = '0;
      shadow_cfg.query_class = 16'd1;
      label_len = '0;
      held_qtype = '0;
      overflow_seen = 1'b0;
      expected_bytes = {};
      errors = 0;
    end else begin
      // Compare each result transfer with the oldest expected byte.
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h", $time,
                   out_byte);
          errors++;
        end else begin
          exp_item = expected_bytes.pop_front();
          check_field("out_byte", exp_item.out_byte, out_byte);
          check_field("last_of_run", exp_item.last_of_run, last_of_run);
          check_field("message_end", exp_item.message_end, message_end);
          check_field("label_overflow", exp_item.label_overflow, label_overflow);
        end
      end

      // Track register writes on the configuration port.
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_RESPONSE_FLAG:      shadow_cfg.response_flag = pwdata[0];
          REG_OPERATION_CODE:     shadow_cfg.operation_code = pwdata[3:0];
          REG_AUTHORITATIVE_FLAG: shadow_cfg.authoritative_flag = pwdata[0];
          REG_TRUNCATED_FLAG:     shadow_cfg.truncated_flag = pwdata[0];
          REG_RECURSION_DESIRED:  shadow_cfg.recursion_desired = pwdata[0];
          REG_RESULT_CODE:        shadow_cfg.result_code = pwdata[3:0];
          REG_QUERY_CLASS:        shadow_cfg.query_class = pwdata[15:0];
          default: ;
        endcase
      end

      // Predict the bytes of each input transfer.
      if (push && !full) encode_item(action_t'(action), name_char);
    end
    mismatches <= errors;
    bytes_waiting <= expected_bytes.size();
  end

endmodule

@@ tb/dns_query_message_encoder_tb.sv @@
`timescale 1ns / 100ps
module dns_query_message_encoder_tb;
  import dqme_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          action = '0;
  logic [15:0]         query_id = '0;
  logic [15:0]         question_count = '0;
  logic [15:0]         answer_count = '0;
  logic [15:0]         authority_count = '0;
  logic [15:0]         additional_count = '0;
  logic [15:0]         query_type = '0;
  logic [7:0]          name_char = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_byte;
  logic                last_of_run;
  logic                message_end;
  logic                label_overflow;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int                  mismatches;
  int                  bytes_waiting;

  int                  send_idle_pct = 27;
  int                  pop_idle_pct = 53;
  int                  items_sent = 0;
  int                  stall_cycles = 0;

  dns_query_message_encoder uut (.*);

  dns_query_message_encoder_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: pop is redrawn every cycle.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Holds push high with the item until the block takes it.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    action <= it.action;
    query_id <= it.query_id;
    question_count <= it.question_count;
    answer_count <= it.answer_count;
    authority_count <= it.authority_count;
    additional_count <= it.additional_count;
    query_type <= it.query_type;
    name_char <= it.name_char;
    items_sent++;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Sends one operation with random content in the other fields.
  task automatic send_op(input action_t act, input logic [7:0] ch);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.action = act;
    it.name_char = ch;
    send_item(it);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = $urandom_range(255); while (c == DOT_CHAR);
    return c;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value,
                           input logic [31:0] mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    apb_write(REG_RESPONSE_FLAG, c.response_flag, 32'h1);
    apb_write(REG_OPERATION_CODE, c.operation_code, 32'hF);
    apb_write(REG_AUTHORITATIVE_FLAG, c.authoritative_flag, 32'h1);
    apb_write(REG_TRUNCATED_FLAG, c.truncated_flag, 32'h1);
    apb_write(REG_RECURSION_DESIRED, c.recursion_desired, 32'h1);
    apb_write(REG_RESULT_CODE, c.result_code, 32'hF);
    apb_write(REG_QUERY_CLASS, c.query_class, 32'hFFFF);
  endtask

  // Drains all results, then gives the back end time to go idle.
  // The count is first given time to take in the last transfer.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (bytes_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One well-formed query: header, up to four labels, finish.
  task automatic send_message();
    int n_labels;
    int len;
    send_op(ACT_BEGIN, $urandom_range(255));
    n_labels = $urandom_range(0, 4);
    for (int l = 0; l < n_labels; l++) begin
      // Now and then a label runs past the maximum length.
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
      repeat (len) send_op(ACT_CHAR, plain_char());
      if (l == n_labels - 1 && $urandom_range(1)) send_op(ACT_END, plain_char());
      else send_op(ACT_CHAR, DOT_CHAR);
    end
    if ($urandom_range(3) == 0) send_op(ACT_END, $urandom_range(255));
    // Leftover characters are dropped by finish.
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) send_op(ACT_CHAR, plain_char());
    send_op(ACT_FINISH, $urandom_range(255));
  endtask

  task automatic run_random(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 15) begin
        send_op(action_t'($urandom_range(3)), $urandom_range(255));
      end else begin
        send_message();
      end
    end
  endtask

  initial begin
    in_item_t it;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part with every register at its maximum.
    write_config('1);
    send_op(ACT_FINISH, 8'h00);
    it = '1;
    it.action = ACT_BEGIN;
    send_item(it);
    send_op(ACT_CHAR, 8'h61);
    send_op(ACT_CHAR, 8'h62);
    send_op(ACT_CHAR, DOT_CHAR);
    send_op(ACT_CHAR, DOT_CHAR);
    send_op(ACT_CHAR, 8'h00);
    send_op(ACT_CHAR, 8'hFF);
    send_op(ACT_END, 8'h00);
    send_op(ACT_END, 8'hFF);
    send_op(ACT_CHAR, 8'h78);
    send_op(ACT_FINISH, 8'h00);
    it = '0;
    send_item(it);
    send_op(ACT_CHAR, 8'h71);
    send_op(ACT_END, 8'h00);
    send_op(ACT_FINISH, 8'h00);

    // Random part under three idle patterns and three settings.
    settle();
    write_config(cfg_t'($urandom));
    run_random(150);

    settle();
    send_idle_pct = 53;
    pop_idle_pct <= 27;
    write_config('0);
    run_random(150);

    settle();
    send_idle_pct = 0;
    pop_idle_pct <= 0;
    write_config(cfg_t'($urandom));
    run_random(150);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dqme_pkg.sv
rtl/core/dqme_ram.sv
rtl/core/dqme_fifo.sv
rtl/core/dqme_front.sv
rtl/core/dqme_back.sv
rtl/core/dns_query_message_encoder.sv
tb/dns_query_message_encoder_checker.sv
tb/dns_query_message_encoder_tb.sv
